// File: rtl/bbn_pkg.sv
// Bounding box normalize: shared types and constants.
// Used by bbn_mul and bounding_box_normalize; no dependencies.
`timescale 1ns / 1ps

package bbn_pkg;

  localparam int DATA_W    = 32;   // coordinate and scale width
  localparam int EXT_W     = 34;   // signed per-axis extent
  localparam int N_W       = 36;   // signed offset numerator
  localparam int INV_W     = 48;   // reciprocal of the extent, 2^47 / E
  localparam int MUL_W     = 64;   // multiplier operand width
  localparam int HALF_W    = 32;   // partial product slice
  localparam int PROD_W    = 128;  // multiplier result width
  localparam int NUM_AXES  = 3;
  localparam int AXIS_W    = 2;
  localparam int DIV_CNT_W = 6;
  localparam int CFG_ADDR_W = 1;

  localparam logic [AXIS_W-1:0]    LAST_AXIS    = 2'd2;
  localparam logic [DIV_CNT_W-1:0] DIV_TOP_BIT  = 6'd47;
  localparam logic [2:0]           MUL_PP_STEPS = 3'd4;
  localparam logic [2:0]           MUL_LAST     = 3'd5;

  localparam logic KIND_MEASURE   = 1'b0;
  localparam logic KIND_TRANSFORM = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS,
    ST_EXT,
    ST_INV,
    ST_DIV,
    ST_CHECK,
    ST_NFORM,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic neg;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// File: rtl/bounding_box_normalize.sv
// Bounding box unit normalization of Q(32-F).F vertex positions, top level.
// Depends on bbn_pkg and bbn_mul.
`timescale 1ns / 1ps

// Items with kind 0 (measure) take an accept step plus one min/max compare
// per axis. Items with kind 1 (transform) take three extent steps, a check,
// then per axis one offset step and two passes through the shared iterative
// multiplier (four 32x32 partial products per pass). A transform item flagged
// first_item with a positive extent adds the bit-serial reciprocal
// 2^47 / extent. A degenerate box skips the multiplier. The input is not
// ready while an item is in work; one finished result is held in the output
// register while the next item is accepted. Configuration writes are taken
// at any time, meant only when idle.

module bounding_box_normalize #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [3*bbn_pkg::DATA_W-1:0]        s_tdata,   // pos_x, pos_y, pos_z
  input  logic [1:0]                          s_tuser,   // kind, first_item
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [3*bbn_pkg::DATA_W-1:0]        m_tdata,   // out_x, out_y, out_z
  output logic                                m_tuser,   // degenerate
  input  logic                                cfg_we,
  input  logic [bbn_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [bbn_pkg::DATA_W-1:0]          cfg_data
);
  import bbn_pkg::*;

  localparam int R_SHIFT = INV_W - FRAC_BITS;
  localparam logic signed [DATA_W-1:0] SCALE_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

  state_t state, state_next;

  logic signed [DATA_W-1:0] scale;
  logic                     center;
  logic signed [DATA_W-1:0] lo  [NUM_AXES];
  logic signed [DATA_W-1:0] hi  [NUM_AXES];
  logic signed [DATA_W-1:0] pos [NUM_AXES];
  logic signed [DATA_W-1:0] res [NUM_AXES];
  logic                     res_degen;
  logic                     item_first;
  logic [AXIS_W-1:0]        axis;
  logic signed [EXT_W-1:0]  ext_max;
  logic [INV_W-1:0]         inverse;
  logic [EXT_W-1:0]         div_rem;
  logic [INV_W-1:0]         div_quo;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic                     out_load;

  logic signed [DATA_W-1:0] cur_p, cur_lo, cur_hi;
  logic signed [EXT_W-1:0]  axis_ext;
  logic                     ext_pos;
  logic signed [N_W-1:0]    p_n, lo_n, hi_n, ext_n, n_val;
  logic [N_W-1:0]           n_abs;
  logic [EXT_W-1:0]         div_shift;
  logic                     div_ge;
  logic [EXT_W-1:0]         div_rem_next;
  logic [MUL_W-1:0]         r_val, r_abs;
  logic [DATA_W-1:0]        scale_abs;
  logic [PROD_W-FRAC_BITS-DATA_W:0] v_top;
  logic signed [DATA_W-1:0] v_sat;

  mul_req_t              mul_req;
  mul_stat_t             mul_stat;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     mul_prod;

  bbn_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .stat (mul_stat),
    .prod (mul_prod)
  );

  // per-axis operand select
  assign cur_p    = pos[axis];
  assign cur_lo   = lo[axis];
  assign cur_hi   = hi[axis];
  assign axis_ext = {{(EXT_W-DATA_W){cur_hi[DATA_W-1]}}, cur_hi}
                  - {{(EXT_W-DATA_W){cur_lo[DATA_W-1]}}, cur_lo};
  assign ext_pos  = !ext_max[EXT_W-1] && (ext_max != '0);

  // offset numerator
  assign p_n   = {{(N_W-DATA_W){cur_p[DATA_W-1]}}, cur_p};
  assign lo_n  = {{(N_W-DATA_W){cur_lo[DATA_W-1]}}, cur_lo};
  assign hi_n  = {{(N_W-DATA_W){cur_hi[DATA_W-1]}}, cur_hi};
  assign ext_n = {{(N_W-EXT_W){ext_max[EXT_W-1]}}, ext_max};
  assign n_val = center ? ((p_n <<< 1) - lo_n - hi_n) : (((p_n - lo_n) <<< 1) - ext_n);
  assign n_abs = n_val[N_W-1] ? (~n_val + N_W'(1)) : n_val;

  // reciprocal, one quotient bit per cycle
  assign div_shift    = {div_rem[EXT_W-2:0], div_cnt == DIV_TOP_BIT};
  assign div_ge       = div_shift >= ext_max;
  assign div_rem_next = div_ge ? (div_shift - ext_max) : div_shift;

  // first product, floor shifted back to Q(F)
  assign r_val     = mul_prod[R_SHIFT +: MUL_W];
  assign r_abs     = r_val[MUL_W-1] ? (~r_val + MUL_W'(1)) : r_val;
  assign scale_abs = scale[DATA_W-1] ? (~scale + DATA_W'(1)) : scale;

  // second product, floor shift and saturate
  assign v_top = mul_prod[PROD_W-1:FRAC_BITS+DATA_W-1];
  assign v_sat = ((&v_top) || !(|v_top)) ? mul_prod[FRAC_BITS +: DATA_W]
               : (mul_prod[PROD_W-1] ? NEG_MAX : POS_MAX);

  assign mul_a = (state == ST_NFORM) ? MUL_W'(n_abs) : r_abs;
  assign mul_b = (state == ST_NFORM) ? MUL_W'(inverse) : MUL_W'(scale_abs);

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mul_req.start = 1'b0;
    mul_req.neg   = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == KIND_MEASURE) ? ST_MEAS : ST_EXT;
        end
      end
      ST_MEAS: begin
        if (axis == LAST_AXIS) state_next = ST_IDLE;
      end
      ST_EXT: begin
        if (axis == LAST_AXIS) state_next = ST_INV;
      end
      ST_INV: begin
        state_next = (item_first && ext_pos) ? ST_DIV : ST_CHECK;
      end
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (inverse == '0 || !ext_pos) ? ST_DONE : ST_NFORM;
      end
      ST_NFORM: begin
        mul_req.start = 1'b1;
        mul_req.neg   = n_val[N_W-1];
        state_next    = ST_MUL1;
      end
      ST_MUL1: begin
        if (mul_stat.done) begin
          mul_req.start = 1'b1;
          mul_req.neg   = r_val[MUL_W-1] ^ scale[DATA_W-1];
          state_next    = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_stat.done) begin
          state_next = (axis == LAST_AXIS) ? ST_DONE : ST_NFORM;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_ONE;
      center   <= 1'b0;
      inverse  <= '0;
      axis     <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        lo[i] <= POS_MAX;
        hi[i] <= NEG_MAX;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SCALE:  scale  <= cfg_data;
          REG_CENTER: center <= cfg_data[0];
          default:    ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          axis <= '0;
        end
        ST_MEAS: begin
          if (item_first) begin
            lo[axis] <= cur_p;
            hi[axis] <= cur_p;
          end else begin
            if (cur_p < cur_lo) lo[axis] <= cur_p;
            if (cur_p > cur_hi) hi[axis] <= cur_p;
          end
          axis <= (axis == LAST_AXIS) ? '0 : axis + 2'd1;
        end
        ST_EXT: begin
          axis <= (axis == LAST_AXIS) ? '0 : axis + 2'd1;
        end
        ST_INV: begin
          if (item_first && !ext_pos) inverse <= '0;
        end
        ST_DIV: begin
          if (div_cnt == '0) inverse <= {div_quo[INV_W-2:0], div_ge};
        end
        ST_CHECK: begin
          axis <= '0;
        end
        ST_MUL2: begin
          if (mul_stat.done && axis != LAST_AXIS) axis <= axis + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pos[0]     <= s_tdata[0 +: DATA_W];
      pos[1]     <= s_tdata[DATA_W +: DATA_W];
      pos[2]     <= s_tdata[2*DATA_W +: DATA_W];
      item_first <= s_tuser[1];
    end

    if (out_load) begin
      m_tdata <= {res[2], res[1], res[0]};
      m_tuser <= res_degen;
    end

    case (state)
      ST_EXT: begin
        if (axis == '0 || axis_ext > ext_max) ext_max <= axis_ext;
      end
      ST_INV: begin
        div_rem <= '0;
        div_quo <= '0;
        div_cnt <= DIV_TOP_BIT;
      end
      ST_DIV: begin
        div_rem <= div_rem_next;
        div_quo <= {div_quo[INV_W-2:0], div_ge};
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
      ST_CHECK: begin
        res_degen <= (inverse == '0 || !ext_pos);
        for (int i = 0; i < NUM_AXES; i++) res[i] <= '0;
      end
      ST_MUL2: begin
        if (mul_stat.done) res[axis] <= v_sat;
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) mul_req.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate item carries nonzero coordinates");

  assert property (@(posedge clk) disable iff (rst) state == ST_DIV |-> ext_pos)
    else $error("reciprocal started on a non-positive extent");

  assert property (@(posedge clk) disable iff (rst) state == ST_NFORM |-> inverse != '0)
    else $error("transform with zero reciprocal");

  assert property (@(posedge clk) disable iff (rst) s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in work");

endmodule

// File: rtl/bbn_mul.sv
// Iterative 64x64 multiplier: one 32x32 partial product per cycle, then sign fix-up.
// Depends on bbn_pkg.
`timescale 1ns / 1ps

module bbn_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  bbn_pkg::mul_req_t              req,
  input  logic [bbn_pkg::MUL_W-1:0]      a,
  input  logic [bbn_pkg::MUL_W-1:0]      b,
  output bbn_pkg::mul_stat_t             stat,
  output logic [bbn_pkg::PROD_W-1:0]     prod
);
  import bbn_pkg::*;

  logic              busy;
  logic              done;
  logic [2:0]        cnt;
  logic [MUL_W-1:0]  op_a;
  logic [MUL_W-1:0]  op_b;
  logic              neg;
  logic [MUL_W-1:0]  pp;
  logic [PROD_W-1:0] acc;
  logic [1:0]        ps;
  logic [PROD_W-1:0] pp_ext;
  logic [PROD_W-1:0] pp_sh;
  logic [HALF_W-1:0] a_half;
  logic [HALF_W-1:0] b_half;

  assign a_half = cnt[0] ? op_a[MUL_W-1:HALF_W] : op_a[HALF_W-1:0];
  assign b_half = cnt[1] ? op_b[MUL_W-1:HALF_W] : op_b[HALF_W-1:0];
  assign ps     = cnt[1:0] - 2'd1;
  assign pp_ext = {{(PROD_W-MUL_W){1'b0}}, pp};

  always_comb begin
    case (ps)
      2'd0:       pp_sh = pp_ext;
      2'd1, 2'd2: pp_sh = pp_ext << HALF_W;
      default:    pp_sh = pp_ext << MUL_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_a <= a;
      op_b <= b;
      neg  <= req.neg;
      acc  <= '0;
    end else if (busy) begin
      if (cnt < MUL_PP_STEPS) begin
        pp <= a_half * b_half;
      end
      if (cnt == MUL_LAST) begin
        acc <= neg ? (~acc + PROD_W'(1)) : acc;
      end else if (cnt != 3'd0) begin
        acc <= acc + pp_sh;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = acc;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for bounding_box_normalize: measure/transform vertex streams,
// scale and centering settings, and random stalls on both stream sides.
// Depends on bbn_pkg and the bounding_box_normalize RTL.
`timescale 1ns / 1ps

module testbench;
  import bbn_pkg::*;

  localparam int FRAC = 16;
  localparam int SETTLE = 150;
  localparam int LIMIT = 1000000;
  localparam int PHASE_ITEMS = 220;
  localparam int LONG_HOLD = 400;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct {
    logic kind;
    logic first;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic degen;
  } vert_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [3*DATA_W-1:0] s_tdata = '0;    // pos_x, pos_y, pos_z
  logic [1:0] s_tuser = '0;             // kind, first_item
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [3*DATA_W-1:0] m_tdata;         // out_x, out_y, out_z
  logic m_tuser;                        // degenerate
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_SCALE;
  logic [DATA_W-1:0] cfg_data = '0;

  bounding_box_normalize #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  longint box_lo[3] = '{SAT_HI, SAT_HI, SAT_HI};
  longint box_hi[3] = '{SAT_LO, SAT_LO, SAT_LO};
  logic [INV_W-1:0] inv_ext = '0;
  longint scale_q = 65536;
  bit center_q = 1'b0;

  vertex_t vertex_q[$];
  vert_res_t expected_norm[$];
  vertex_t cur_vtx;

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_degen = 0;
  int n_errors = 0;
  int n_settings = 0;
  int n_cycles = 0;
  int src_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;

  // floor(a * b / 2^sh), clamped to +-2^62
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic signed [127:0] wa, wb, q;
    wa = a;
    wb = b;
    q = (wa * wb) >>> sh;
    if (q > (128'sd1 <<< 62)) q = 128'sd1 <<< 62;
    if (q < -(128'sd1 <<< 62)) q = -(128'sd1 <<< 62);
    return longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] norm_axis(longint p, longint lo, longint hi, longint ext);
    longint n, r, v;
    n = center_q ? 2 * p - lo - hi : 2 * (p - lo) - ext;
    r = scaled_product(n, longint'({16'd0, inv_ext}), INV_W - FRAC);
    v = scaled_product(r, scale_q, FRAC);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[31:0];
  endfunction

  task automatic predict_vertex(input vertex_t v);
    longint pos[3];
    longint ext, e;
    vert_res_t r;
    pos[0] = v.x;
    pos[1] = v.y;
    pos[2] = v.z;
    if (v.kind == KIND_MEASURE) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (v.first) begin
          box_lo[a] = pos[a];
          box_hi[a] = pos[a];
        end else begin
          if (pos[a] < box_lo[a]) box_lo[a] = pos[a];
          if (pos[a] > box_hi[a]) box_hi[a] = pos[a];
        end
      end
    end else begin
      ext = box_hi[0] - box_lo[0];
      for (int a = 1; a < NUM_AXES; a++) begin
        e = box_hi[a] - box_lo[a];
        if (e > ext) ext = e;
      end
      if (v.first) inv_ext = (ext > 0) ? INV_W'((longint'(1) <<< 47) / ext) : '0;
      if (inv_ext == 0 || ext <= 0) begin
        r = '{32'd0, 32'd0, 32'd0, 1'b1};
      end else begin
        r.x = norm_axis(pos[0], box_lo[0], box_hi[0], ext);
        r.y = norm_axis(pos[1], box_lo[1], box_hi[1], ext);
        r.z = norm_axis(pos[2], box_lo[2], box_hi[2], ext);
        r.degen = 1'b0;
      end
      expected_norm = {expected_norm, r};
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_vertex(cur_vtx);
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (vertex_q.size() != 0) begin
          if (idle_on && $urandom_range(0, 15) == 0) begin
            src_gap <= $urandom_range(0, 18);
            s_tvalid <= 1'b0;
          end else begin
            cur_vtx = vertex_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= {cur_vtx.z, cur_vtx.y, cur_vtx.x};
            s_tuser <= {cur_vtx.first, cur_vtx.kind};
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : rx_side
    vert_res_t want;
    bit start_hold;
    start_hold = 1'b0;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (m_tuser) n_degen++;
        if (n_results == 60) start_hold = 1'b1;
        if (expected_norm.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got %h degenerate %b",
                   $time, m_tdata, m_tuser);
          n_errors++;
        end else begin
          want = expected_norm.pop_front();
          check_field("out_x", want.x, m_tdata[DATA_W-1:0]);
          check_field("out_y", want.y, m_tdata[2*DATA_W-1:DATA_W]);
          check_field("out_z", want.z, m_tdata[3*DATA_W-1:2*DATA_W]);
          check_field("degenerate", {31'd0, want.degen}, {31'd0, m_tuser});
        end
      end
      if (start_hold) begin
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        rx_gap <= $urandom_range(0, 18);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == LIMIT) begin
      $display("bounding_box_normalize regression: fail");
      $finish;
    end
  end

  task automatic push_vertex(logic kind, logic first, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    vertex_t v;
    v.kind = kind;
    v.first = first;
    v.x = x;
    v.y = y;
    v.z = z;
    vertex_q = {vertex_q, v};
    n_queued++;
  endtask

  task automatic set_config(logic signed [31:0] scale, logic center);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_SCALE;
    cfg_data <= scale;
    @(posedge clk);
    cfg_addr <= REG_CENTER;
    cfg_data <= {31'd0, center};
    @(posedge clk);
    cfg_we <= 1'b0;
    scale_q = scale;
    center_q = center;
    n_settings++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_queued || expected_norm.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_spread();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd255;
      3: return 32'd65535;
      4: return 32'd1 << 20;
      5: return 32'd1 << 26;
      6: return $urandom;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_extreme(logic [31:0] base);
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return base;
    endcase
  endfunction

  // one measure pass followed by one transform pass over the same box
  task automatic add_mesh(bit drop_meas_first, bit drop_xf_first);
    int unsigned style, n_meas, n_xf;
    logic [31:0] base[3];
    logic [31:0] spread[3];
    logic [31:0] p[3];
    style = $urandom_range(0, 3);
    for (int a = 0; a < NUM_AXES; a++) begin
      base[a] = (style == 0) ? $urandom : $urandom_range(0, 1 << 21) - (1 << 20);
      spread[a] = pick_spread();
      if (style == 2) spread[a] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
    end
    n_meas = $urandom_range(1, 6);
    n_xf = $urandom_range(1, 6);
    for (int i = 0; i < n_meas + n_xf; i++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (style == 3) p[a] = pick_extreme(base[a]);
        else p[a] = base[a] + $urandom_range(0, spread[a]);
        if (i >= n_meas && $urandom_range(0, 7) == 0) p[a] = $urandom;
      end
      if (i < n_meas)
        push_vertex(KIND_MEASURE, i == 0 && !drop_meas_first, p[0], p[1], p[2]);
      else
        push_vertex(KIND_TRANSFORM, i == n_meas && !drop_xf_first, p[0], p[1], p[2]);
    end
  endtask

  task automatic add_random(int target);
    int stop_at;
    stop_at = n_queued + target;
    while (n_queued < stop_at) begin
      case ($urandom_range(0, 9))
        0: push_vertex(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom, $urandom, $urandom);
        1: add_mesh(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: add_mesh(1'b0, 1'b0);
      endcase
    end
  endtask

  initial begin
    logic signed [31:0] phase_scale[6];
    logic phase_center[6];
    phase_scale = '{32'sd65536, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 32'sd0, -32'sd65536};
    phase_center = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    // transform before any measure pass, then without a reciprocal
    push_vertex(KIND_TRANSFORM, 1'b1, 32'd0, 32'd0, 32'd0);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    // single point box
    push_vertex(KIND_MEASURE, 1'b0, 32'd5, 32'd5, 32'd5);
    push_vertex(KIND_TRANSFORM, 1'b1, 32'd5, 32'd5, 32'd5);
    // full range box
    push_vertex(KIND_MEASURE, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vertex(KIND_MEASURE, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vertex(KIND_TRANSFORM, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'd0, 32'd1, 32'hFFFF_0000);
    // flat box, vertices far outside saturate
    push_vertex(KIND_MEASURE, 1'b1, 32'd0, 32'd0, 32'd0);
    push_vertex(KIND_MEASURE, 1'b0, 32'd65536, 32'd0, 32'd0);
    push_vertex(KIND_TRANSFORM, 1'b1, 32'd32768, 32'd0, 32'd0);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'hFFFF_0000, 32'd65536, 32'd0);
    // small box
    push_vertex(KIND_MEASURE, 1'b1, -32'sd100, 32'sd200, 32'sd3);
    push_vertex(KIND_MEASURE, 1'b0, 32'sd100, -32'sd200, 32'sd3);
    push_vertex(KIND_MEASURE, 1'b0, 32'sd0, 32'sd0, 32'sd50);
    push_vertex(KIND_TRANSFORM, 1'b1, -32'sd100, -32'sd200, 32'sd3);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'sd100, 32'sd200, 32'sd50);
    // new box, stale reciprocal
    push_vertex(KIND_MEASURE, 1'b1, 32'd0, 32'd0, 32'd0);
    push_vertex(KIND_MEASURE, 1'b0, 32'd1, 32'd0, 32'd0);
    push_vertex(KIND_TRANSFORM, 1'b0, 32'd1, 32'd0, 32'd0);
    push_vertex(KIND_TRANSFORM, 1'b1, 32'd1, 32'd0, 32'd0);
    wait_idle();

    phase_scale[4] = $urandom_range(0, 1 << 18) - (1 << 17);
    phase_center[4] = 1'($urandom_range(0, 1));
    for (int ph = 0; ph < 6; ph++) begin
      set_config(phase_scale[ph], phase_center[ph]);
      if (ph == 5) idle_on = 1'b0;
      @(negedge clk);
      add_random(PHASE_ITEMS);
      wait_idle();
    end

    if (expected_norm.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_norm.size());
      n_errors++;
    end
    $display("Sent %0d vertices under %0d scale/centering settings;", n_accepted, n_settings);
    $display("checked %0d normalized results, %0d of them degenerate.", n_results, n_degen);
    if (n_errors == 0) begin
      $display("bounding_box_normalize regression: pass");
    end else begin
      $display("bounding_box_normalize regression: fail");
    end
    $finish;
  end

endmodule
